/* rtl/tgad_pkg.sv */
`default_nettype none

package tgad_pkg;

   // field widths of the stream and of the results
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned PixelWidth = 32;
   localparam int unsigned CoordWidth = 16;
   localparam int unsigned CountWidth = 8;
   localparam int unsigned GatherWidth = 24;

   // configuration register map (byte address bit 2 selects the register)
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   // header byte layout
   localparam int unsigned HeaderKindBit = 7;

   // color byte that completes a pixel
   localparam logic [1:0] LAST_COLOR_BYTE = 2'd3;

   // pixel record handed from the byte parser to the row tracker
   typedef struct packed {
      logic [PixelWidth-1:0] pixel_value;
      logic [CoordWidth-1:0] first_column;
      logic [CountWidth-1:0] repeat_count;
      logic                  row_done;
      logic                  was_clipped;
   } pixel_rec_type;

   // a size of zero counts as one
   function automatic logic [CoordWidth-1:0] eff_size(input logic [CoordWidth-1:0] v);
      return (v == '0) ? CoordWidth'(1) : v;
   endfunction

endpackage

`default_nettype wire

/* rtl/tgad_front.sv */
`default_nettype none

module tgad_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            restart,
   input  wire logic [tgad_pkg::CoordWidth-1:0] image_width,
   input  wire logic                            in_valid,
   input  wire logic [tgad_pkg::ByteWidth-1:0]  in_byte,
   output logic                                 in_ready,
   input  wire logic                            queue_full,
   output logic                                 push,
   output tgad_pkg::pixel_rec_type              push_data
);
   import tgad_pkg::*;

   logic                    expect_ff, expect_in;
   logic                    run_ff, run_in;
   logic [CountWidth-1:0]   left_ff, left_in;
   logic [1:0]              pos_ff, pos_in;
   logic [GatherWidth-1:0]  gather_ff, gather_in;
   logic                    clip_ff, clip_in;
   logic [CoordWidth-1:0]   col_ff, col_in;

   logic                    accept;
   logic [CoordWidth-1:0]   width_eff;
   logic [CoordWidth:0]     room;
   logic [CountWidth-1:0]   count;
   logic [CountWidth-1:0]   reps;
   logic [CoordWidth:0]     col_sum;
   logic                    rdone;

   assign in_ready  = !queue_full;
   assign accept    = in_valid && !queue_full;
   assign width_eff = eff_size(image_width);

   // header arithmetic: requested count against room left in the row
   assign count = {1'b0, in_byte[HeaderKindBit-1:0]} + CountWidth'(1);
   assign room  = {1'b0, width_eff} - {1'b0, col_ff};

   // pixel arithmetic: column after this pixel or run
   assign reps    = run_ff ? left_ff : CountWidth'(1);
   assign col_sum = {1'b0, col_ff} + {{(CoordWidth+1-CountWidth){1'b0}}, reps};
   assign rdone   = col_sum >= {1'b0, width_eff};

   // parser next state
   always_comb begin
      expect_in = expect_ff;
      run_in    = run_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      gather_in = gather_ff;
      clip_in   = clip_ff;
      col_in    = col_ff;
      push      = 1'b0;
      if (accept) begin
         if (expect_ff) begin
            if ({{(CoordWidth+1-CountWidth){1'b0}}, count} > room) begin
               left_in = room[CountWidth-1:0];
               clip_in = 1'b1;
            end else begin
               left_in = count;
               clip_in = 1'b0;
            end
            run_in    = in_byte[HeaderKindBit];
            pos_in    = '0;
            gather_in = '0;
            expect_in = 1'b0;
         end else if (pos_ff != LAST_COLOR_BYTE) begin
            case (pos_ff)
               2'd0:    gather_in[7:0]   = in_byte;
               2'd1:    gather_in[15:8]  = in_byte;
               default: gather_in[23:16] = in_byte;
            endcase
            pos_in = pos_ff + 2'd1;
         end else begin
            push      = 1'b1;
            pos_in    = '0;
            gather_in = '0;
            left_in   = run_ff ? '0 : left_ff - CountWidth'(1);
            expect_in = run_ff || (left_ff == CountWidth'(1));
            col_in    = col_sum[CoordWidth-1:0];
            if (rdone) begin
               col_in    = '0;
               expect_in = 1'b1;
               left_in   = '0;
            end
         end
      end
   end

   // record of the finished pixel
   always_comb begin
      push_data.pixel_value  = {in_byte, gather_ff};
      push_data.first_column = col_ff;
      push_data.repeat_count = reps;
      push_data.row_done     = rdone;
      push_data.was_clipped  = clip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         expect_ff <= 1'b1;
         run_ff    <= 1'b0;
         left_ff   <= '0;
         pos_ff    <= '0;
         gather_ff <= '0;
         clip_ff   <= 1'b0;
         col_ff    <= '0;
      end else begin
         expect_ff <= expect_in;
         run_ff    <= run_in;
         left_ff   <= left_in;
         pos_ff    <= pos_in;
         gather_ff <= gather_in;
         clip_ff   <= clip_in;
         col_ff    <= col_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tgad_queue.sv */
`default_nettype none

module tgad_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    clear,
   input  wire logic                    push,
   input  wire tgad_pkg::pixel_rec_type push_data,
   input  wire logic                    pop,
   output tgad_pkg::pixel_rec_type      pop_data,
   output logic                         empty,
   output logic                         full
);
   import tgad_pkg::*;

   pixel_rec_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    fill_ff, fill_in;

   assign empty    = (fill_ff == 2'd0);
   assign full     = (fill_ff == 2'd2);
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/tgad_back.sv */
`default_nettype none

module tgad_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             restart,
   input  wire logic [tgad_pkg::CoordWidth-1:0]  restart_row,
   input  wire logic [tgad_pkg::CoordWidth-1:0]  image_height,
   input  wire logic                             queue_empty,
   input  wire tgad_pkg::pixel_rec_type          queue_data,
   output logic                                  pop,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic [tgad_pkg::PixelWidth-1:0]       pixel_value,
   output logic [tgad_pkg::CoordWidth-1:0]       row_index,
   output logic [tgad_pkg::CoordWidth-1:0]       first_column,
   output logic [tgad_pkg::CountWidth-1:0]       repeat_count,
   output logic                                  row_done,
   output logic                                  image_done,
   output logic                                  was_clipped
);
   import tgad_pkg::*;

   logic                  valid_ff, valid_in;
   logic [CoordWidth-1:0] row_ff, row_in;
   logic                  last_row;

   logic [PixelWidth-1:0] pixel_ff;
   logic [CoordWidth-1:0] row_out_ff;
   logic [CoordWidth-1:0] col_ff;
   logic [CountWidth-1:0] reps_ff;
   logic                  rdone_ff;
   logic                  idone_ff;
   logic                  clip_ff;

   // take the next record whenever the output register is free
   assign pop      = !queue_empty && (!valid_ff || out_ready);
   assign last_row = (row_ff == '0);

   always_comb begin
      valid_in = valid_ff;
      row_in   = row_ff;
      if (pop) begin
         valid_in = 1'b1;
         if (queue_data.row_done) begin
            row_in = last_row ? eff_size(image_height) - CoordWidth'(1)
                              : row_ff - CoordWidth'(1);
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   // row tracking and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         row_ff   <= '0;
      end else if (restart) begin
         valid_ff <= 1'b0;
         row_ff   <= restart_row;
      end else begin
         valid_ff <= valid_in;
         row_ff   <= row_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         pixel_ff   <= queue_data.pixel_value;
         row_out_ff <= row_ff;
         col_ff     <= queue_data.first_column;
         reps_ff    <= queue_data.repeat_count;
         rdone_ff   <= queue_data.row_done;
         idone_ff   <= queue_data.row_done && last_row;
         clip_ff    <= queue_data.was_clipped;
      end
   end

   assign out_valid    = valid_ff;
   assign pixel_value  = pixel_ff;
   assign row_index    = row_out_ff;
   assign first_column = col_ff;
   assign repeat_count = reps_ff;
   assign row_done     = rdone_ff;
   assign image_done   = idone_ff;
   assign was_clipped  = clip_ff;

endmodule

`default_nettype wire

/* rtl/tga_rle_pixel_decoder_unit.sv */
`default_nettype none

// Run-length pixel decoder for 32-bit TGA images.
// req_ channel: one byte of the compressed pixel data per transfer.
// rsp_ channel: one transfer per decoded raw pixel or run, with the pixel,
//   its destination row and start column and the repeat count; tlast marks
//   the result that completes a row, tuser carries image done and clip flags.
// csr_ port: image_width at byte address 0, image_height at address 4;
//   writing either one restarts decoding at the top row of a new image.
// A result reaches rsp_ from the transfer of the fourth color byte of its
//   pixel through the record queue write, then the result register.
// Throughput: one byte per cycle unless the record queue is full; the parser
//   updates its counters per byte and the two-entry queue absorbs short rsp_ stalls.
// When rsp_ stalls, the result register holds and the queue fills; once it
//   is full req_tready drops until the receiver takes a result.
// Reset clears all decode state, sets both size registers to one and
//   awaits a packet header byte; no result is pending after reset.
module tga_rle_pixel_decoder_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // byte stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // stream_byte
   // results
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // pixel_value[31:0], row_index[47:32], first_column[63:48], repeat_count[71:64]
   output logic [71:0]                            rsp_tdata,
   output logic                                   rsp_tlast,  // row_done
   output logic [1:0]                             rsp_tuser,  // was_clipped, image_done
   // configuration
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tgad_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [tgad_pkg::CsrDataWidth-1:0] csr_pwdata,
   output logic [tgad_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic                                   csr_pready
);
   import tgad_pkg::*;

   logic [CoordWidth-1:0] width_ff, width_in;
   logic [CoordWidth-1:0] height_ff, height_in;
   logic                  csr_write;
   logic                  restart;
   logic [CoordWidth-1:0] restart_row;

   logic                  push;
   pixel_rec_type         push_data;
   logic                  pop;
   pixel_rec_type         pop_data;
   logic                  queue_empty;
   logic                  queue_full;

   logic [PixelWidth-1:0] pixel_value;
   logic [CoordWidth-1:0] row_index;
   logic [CoordWidth-1:0] first_column;
   logic [CountWidth-1:0] repeat_count;
   logic                  row_done;
   logic                  image_done;
   logic                  was_clipped;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign restart    = csr_write;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_IMAGE_WIDTH:  width_in  = csr_pwdata[CoordWidth-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_pwdata[CoordWidth-1:0];
            default:          width_in  = width_ff;
         endcase
      end
   end

   assign restart_row = eff_size(height_in) - CoordWidth'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CoordWidth'(1);
         height_ff <= CoordWidth'(1);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // register read back
   always_comb begin
      unique case (csr_paddr[2])
         CSR_IMAGE_WIDTH:  csr_prdata = {{(CsrDataWidth-CoordWidth){1'b0}}, width_ff};
         CSR_IMAGE_HEIGHT: csr_prdata = {{(CsrDataWidth-CoordWidth){1'b0}}, height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // byte parser
   tgad_front u_front (
      .clock       (clock),
      .reset       (reset),
      .restart     (restart),
      .image_width (width_ff),
      .in_valid    (req_tvalid),
      .in_byte     (req_tdata),
      .in_ready    (req_tready),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   // record queue between parser and row tracker
   tgad_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .clear     (restart),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // row tracker and result register
   tgad_back u_back (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .restart_row  (restart_row),
      .image_height (height_ff),
      .queue_empty  (queue_empty),
      .queue_data   (pop_data),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .pixel_value  (pixel_value),
      .row_index    (row_index),
      .first_column (first_column),
      .repeat_count (repeat_count),
      .row_done     (row_done),
      .image_done   (image_done),
      .was_clipped  (was_clipped)
   );

   // result packing
   assign rsp_tdata = {repeat_count, first_column, row_index, pixel_value};
   assign rsp_tlast = row_done;
   assign rsp_tuser = {was_clipped, image_done};

endmodule

`default_nettype wire
